[hw/rtl/isotp_pkg.sv]
`timescale 1ns / 1ps

package isotp_pkg;

    // default sizing
    localparam int ISOTP_NUM_CHANNELS = 8;
    localparam int ISOTP_BUFFER_BYTES = 512;

    // field widths
    localparam int LEN_W    = 12;
    localparam int SEQ_W    = 4;
    localparam int BYTES_W  = 56;
    localparam int NUM_W    = 3;
    localparam int CFG_W    = 9;
    localparam int CFG_IX_W = 2;

    // protocol constants
    localparam logic [7:0]       FC_PCI_CTS   = 8'h30;
    localparam logic [7:0]       SF_MAX_LEN   = 8'd7;
    localparam logic [LEN_W-1:0] FF_MIN_LEN   = 12'd8;
    localparam logic [3:0]       FF_DLC       = 4'd8;
    localparam logic [NUM_W-1:0] FF_STORED    = 3'd6;
    localparam logic [NUM_W-1:0] CF_MAX_BYTES = 3'd7;
    localparam logic [SEQ_W-1:0] FF_NEXT_SEQ  = 4'd1;

    // configuration reset values
    localparam logic [7:0]       CFG_BS_RST     = 8'd0;
    localparam logic [7:0]       CFG_ST_RST     = 8'd20;
    localparam logic [CFG_W-1:0] CFG_MAXLEN_RST = 9'd260;

    // pci frame types (high nibble of byte 0)
    localparam logic [3:0] PCI_SINGLE = 4'h0;
    localparam logic [3:0] PCI_FIRST  = 4'h1;
    localparam logic [3:0] PCI_CONSEC = 4'h2;
    localparam logic [3:0] PCI_FLOW   = 4'h3;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_REJECTED = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_READ     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        KIND_SINGLE  = 3'd0,
        KIND_FIRST   = 3'd1,
        KIND_CONSEC  = 3'd2,
        KIND_FLOW    = 3'd3,
        KIND_UNKNOWN = 3'd4
    } t_kind;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_BLOCK_SIZE = 2'd0,
        CFG_SEP_TIME   = 2'd1,
        CFG_MAX_LENGTH = 2'd2
    } t_cfg_idx;

    // per-channel reassembly state
    typedef struct packed {
        logic             receiving;
        logic [LEN_W-1:0] exp_len;
        logic [LEN_W-1:0] rcv_cnt;
        logic [SEQ_W-1:0] next_seq;
    } t_chan_state;

    // burst of buffer bytes for one frame
    typedef struct packed {
        logic [LEN_W-1:0]   pos;
        logic [NUM_W-1:0]   num;
        logic [BYTES_W-1:0] bytes;
    } t_wr_req;

    // decoded frame outcome
    typedef struct packed {
        t_status          status;
        t_kind            kind;
        logic [LEN_W-1:0] mlen;
        logic             sfc;
        logic [63:0]      fcd;
        t_chan_state      nxt;
        t_wr_req          wr;
    } t_dec_res;

endpackage

[hw/rtl/isotp_in_if.sv]
`timescale 1ns / 1ps

interface isotp_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [2:0]  channel;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_data;
    logic [8:0]  read_index;

    modport source (output valid, command, channel, frame_dlc, frame_data, read_index,
                    input ready);
    modport sink (input valid, command, channel, frame_dlc, frame_data, read_index,
                  output ready);
endinterface

[hw/rtl/isotp_out_if.sv]
`timescale 1ns / 1ps

interface isotp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  frame_kind;
    logic [11:0] message_length;
    logic        send_flow_control;
    logic [63:0] flow_control_data;
    logic [7:0]  read_byte;

    modport source (output valid, status, frame_kind, message_length, send_flow_control,
                    flow_control_data, read_byte, input ready);
    modport sink (input valid, status, frame_kind, message_length, send_flow_control,
                  flow_control_data, read_byte, output ready);
endinterface

[hw/rtl/isotp_cfg_if.sv]
`timescale 1ns / 1ps

interface isotp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [8:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

[hw/rtl/isotp_receive_reassembler.sv]
`timescale 1ns / 1ps

// ISO-TP receive reassembler for up to NUM_CHANNELS logical channels. Each request is either a
// received CAN frame or a read of one byte of a channel's reassembly buffer, and it produces
// exactly one response via the decode stage register and the output register, leaving the
// decode stage when the output side is free and no buffer write holds it back. Channel state
// sits in a small state memory, read on acceptance and written back when the request leaves
// the decode stage, with forwarding between requests to the same channel. Frame data bytes go
// into the buffer memory through a byte-serial writer: a frame that stores n bytes (up to 7)
// keeps the writer busy until they are written, and a following data frame or read waits until
// it drains; flow-control and rejected frames pass at one per cycle while the output is free.
// The buffer needs no clearing after reset; only bytes that were written may be read back.
// The user must write configuration registers while the block is idle; nothing enforces it.

module isotp_receive_reassembler import isotp_pkg::*; #(
    parameter int NUM_CHANNELS = ISOTP_NUM_CHANNELS,
    parameter int BUFFER_BYTES = ISOTP_BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isotp_in_if.sink    i_in,
    isotp_out_if.source o_out,
    isotp_cfg_if.sink   i_cfg
);

    localparam int CH_W = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

    logic [7:0]       r_fc_bs;
    logic [7:0]       r_fc_st;
    logic [CFG_W-1:0] r_max_len;

    logic             r_s1_valid;
    logic             r_s1_cmd;
    logic             r_s1_ch_ok;
    logic [CH_W-1:0]  r_s1_ch;
    logic [3:0]       r_s1_dlc;
    logic [63:0]      r_s1_data;
    logic [8:0]       r_s1_ridx;

    logic             r_out_valid;
    t_status          r_out_status;
    t_kind            r_out_kind;
    logic [LEN_W-1:0] r_out_mlen;
    logic             r_out_sfc;
    logic [63:0]      r_out_fcd;
    logic             r_out_rd_ok;

    logic             in_accept;
    logic             in_ch_ok;
    logic [CH_W-1:0]  in_ch;
    logic             out_free;
    logic             s1_adv;
    logic             s1_rd_ok;
    logic             wr_busy;
    logic             wr_ok;
    logic [7:0]       rd_byte;
    t_chan_state      cur_state;
    t_dec_res         dec;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc_bs   <= CFG_BS_RST;
            r_fc_st   <= CFG_ST_RST;
            r_max_len <= CFG_MAXLEN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_BLOCK_SIZE: r_fc_bs   <= i_cfg.wdata[7:0];
                CFG_SEP_TIME:   r_fc_st   <= i_cfg.wdata[7:0];
                CFG_MAX_LENGTH: r_max_len <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // input handshake and channel range check
    assign in_ch     = CH_W'(i_in.channel);
    assign in_ch_ok  = 32'(i_in.channel) < NUM_CHANNELS;
    assign out_free  = !r_out_valid || o_out.ready;
    assign wr_ok     = r_s1_cmd ? !wr_busy : (dec.wr.num == '0 || !wr_busy);
    assign s1_adv    = r_s1_valid && out_free && wr_ok;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_accept = i_in.valid && i_in.ready;
    assign s1_rd_ok  = r_s1_ch_ok && 32'(r_s1_ridx) < BUFFER_BYTES;

    // decode stage request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd   <= i_in.command;
            r_s1_ch_ok <= in_ch_ok;
            r_s1_ch    <= in_ch;
            r_s1_dlc   <= i_in.frame_dlc;
            r_s1_data  <= i_in.frame_data;
            r_s1_ridx  <= i_in.read_index;
        end
    end

    isotp_state_ram #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_state_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_ch    (in_ch),
        .i_wr_en    (s1_adv && !r_s1_cmd && r_s1_ch_ok),
        .i_wr_ch    (r_s1_ch),
        .i_wr_state (dec.nxt),
        .o_rd_state (cur_state)
    );

    isotp_frame_dec #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_frame_dec (
        .i_is_read (r_s1_cmd),
        .i_ch_ok   (r_s1_ch_ok),
        .i_dlc     (r_s1_dlc),
        .i_data    (r_s1_data),
        .i_state   (cur_state),
        .i_fc_bs   (r_fc_bs),
        .i_fc_st   (r_fc_st),
        .i_max_len (r_max_len),
        .o_res     (dec)
    );

    isotp_buf #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_load (s1_adv && dec.wr.num != '0),
        .i_wr_ch   (r_s1_ch),
        .i_wr_req  (dec.wr),
        .o_busy    (wr_busy),
        .i_rd_en   (s1_adv && r_s1_cmd && s1_rd_ok),
        .i_rd_ch   (r_s1_ch),
        .i_rd_idx  (r_s1_ridx),
        .o_rd_byte (rd_byte)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= dec.status;
            r_out_kind   <= dec.kind;
            r_out_mlen   <= dec.mlen;
            r_out_sfc    <= dec.sfc;
            r_out_fcd    <= dec.fcd;
            r_out_rd_ok  <= r_s1_cmd && s1_rd_ok;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_out_status;
    assign o_out.frame_kind        = r_out_kind;
    assign o_out.message_length    = r_out_mlen;
    assign o_out.send_flow_control = r_out_sfc;
    assign o_out.flow_control_data = r_out_fcd;
    assign o_out.read_byte         = r_out_rd_ok ? rd_byte : 8'h00;

endmodule

[hw/rtl/isotp_state_ram.sv]
`timescale 1ns / 1ps

module isotp_state_ram import isotp_pkg::*; #(
    parameter int NUM_CHANNELS = ISOTP_NUM_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] i_rd_ch,
    input  logic        i_wr_en,
    input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] i_wr_ch,
    input  t_chan_state i_wr_state,
    output t_chan_state o_rd_state
);

    t_chan_state             mem [NUM_CHANNELS];
    t_chan_state             r_rd_data;
    logic [NUM_CHANNELS-1:0] r_vld;
    logic                    r_rd_vld;
    logic                    r_fwd;
    t_chan_state             r_fwd_state;

    // state memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_ch] <= i_wr_state;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_ch];
        end
    end

    // entries not yet written read as reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_ch] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_ch];
                r_fwd    <= i_wr_en && (i_wr_ch == i_rd_ch);
            end
        end
    end

    // forward a write that lands on the entry being read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_state <= i_wr_state;
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_rd_state = r_fwd_state;
        end else if (r_rd_vld) begin
            o_rd_state = r_rd_data;
        end else begin
            o_rd_state = '0;
        end
    end

endmodule

[hw/rtl/isotp_buf.sv]
`timescale 1ns / 1ps

module isotp_buf import isotp_pkg::*; #(
    parameter int NUM_CHANNELS = ISOTP_NUM_CHANNELS,
    parameter int BUFFER_BYTES = ISOTP_BUFFER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_load,
    input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] i_wr_ch,
    input  t_wr_req    i_wr_req,
    output logic       o_busy,
    input  logic       i_rd_en,
    input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] i_rd_ch,
    input  logic [8:0] i_rd_idx,
    output logic [7:0] o_rd_byte
);

    localparam int CH_W   = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
    localparam int POS_W  = $clog2(BUFFER_BYTES);
    localparam int DEPTH  = NUM_CHANNELS * BUFFER_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]         mem [DEPTH];
    logic               r_busy;
    logic [NUM_W-1:0]   r_left;
    logic [CH_W-1:0]    r_ch;
    logic [POS_W-1:0]   r_pos;
    logic [BYTES_W-1:0] r_bytes;
    logic [7:0]         r_rd_byte;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    // channel base plus byte position
    assign wr_addr = ADDR_W'(r_ch) * ADDR_W'(BUFFER_BYTES) + ADDR_W'(r_pos);
    assign rd_addr = ADDR_W'(i_rd_ch) * ADDR_W'(BUFFER_BYTES) + ADDR_W'(i_rd_idx);

    // byte memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[wr_addr] <= r_bytes[7:0];
        end
        if (i_rd_en) begin
            r_rd_byte <= mem[rd_addr];
        end
    end

    // burst writer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_wr_load) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_left == NUM_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    // burst writer payload, one byte per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_load) begin
            r_left  <= i_wr_req.num;
            r_ch    <= i_wr_ch;
            r_pos   <= POS_W'(i_wr_req.pos);
            r_bytes <= i_wr_req.bytes;
        end else if (r_busy) begin
            r_left  <= r_left - NUM_W'(1);
            r_pos   <= r_pos + POS_W'(1);
            r_bytes <= {8'h00, r_bytes[BYTES_W-1:8]};
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_byte = r_rd_byte;

endmodule

[hw/rtl/isotp_frame_dec.sv]
`timescale 1ns / 1ps

module isotp_frame_dec import isotp_pkg::*; #(
    parameter int BUFFER_BYTES = ISOTP_BUFFER_BYTES
) (
    input  logic             i_is_read,
    input  logic             i_ch_ok,
    input  logic [3:0]       i_dlc,
    input  logic [63:0]      i_data,
    input  t_chan_state      i_state,
    input  logic [7:0]       i_fc_bs,
    input  logic [7:0]       i_fc_st,
    input  logic [CFG_W-1:0] i_max_len,
    output t_dec_res         o_res
);

    logic [7:0]       pci;
    logic [LEN_W-1:0] ff_len;
    logic [LEN_W-1:0] rem;
    logic [NUM_W-1:0] cf_num;
    logic [LEN_W:0]   cf_sum;
    logic             reject;

    assign pci    = i_data[7:0];
    assign ff_len = {pci[3:0], i_data[15:8]};

    // consecutive frame byte count and new fill level
    always_comb begin
        rem    = (i_state.exp_len > i_state.rcv_cnt) ? i_state.exp_len - i_state.rcv_cnt
                                                     : '0;
        cf_num = (rem < LEN_W'(CF_MAX_BYTES)) ? rem[NUM_W-1:0] : CF_MAX_BYTES;
        cf_sum = {1'b0, i_state.rcv_cnt} + (LEN_W + 1)'(cf_num);
    end

    // frame classification and state update
    always_comb begin
        o_res        = '0;
        o_res.status = ST_ACCEPTED;
        o_res.kind   = KIND_SINGLE;
        o_res.nxt    = i_state;
        reject       = 1'b0;
        if (i_is_read) begin
            o_res.status = ST_READ;
        end else if (!i_ch_ok) begin
            o_res.status = ST_REJECTED;
            o_res.kind   = KIND_UNKNOWN;
        end else begin
            unique case (pci[7:4])
                PCI_SINGLE: begin
                    o_res.kind        = KIND_SINGLE;
                    o_res.nxt.exp_len = LEN_W'(pci);
                    if (pci == 8'd0 || pci > SF_MAX_LEN) begin
                        reject = 1'b1;
                    end else begin
                        o_res.wr.num        = pci[NUM_W-1:0];
                        o_res.wr.bytes      = i_data[63:8];
                        o_res.nxt.receiving = 1'b0;
                        o_res.status        = ST_COMPLETE;
                    end
                end
                PCI_FIRST: begin
                    o_res.kind = KIND_FIRST;
                    if (i_dlc != FF_DLC) begin
                        reject = 1'b1;
                    end else begin
                        o_res.nxt.exp_len = ff_len;
                        if (ff_len < FF_MIN_LEN || ff_len > LEN_W'(i_max_len)
                                || {1'b0, ff_len} > (LEN_W + 1)'(BUFFER_BYTES)) begin
                            reject = 1'b1;
                        end else begin
                            o_res.wr.num        = FF_STORED;
                            o_res.wr.bytes      = {8'h00, i_data[63:16]};
                            o_res.nxt.rcv_cnt   = LEN_W'(FF_STORED);
                            o_res.nxt.next_seq  = FF_NEXT_SEQ;
                            o_res.nxt.receiving = 1'b1;
                            o_res.sfc           = 1'b1;
                            o_res.fcd           = {40'h0, i_fc_st, i_fc_bs, FC_PCI_CTS};
                        end
                    end
                end
                PCI_CONSEC: begin
                    o_res.kind = KIND_CONSEC;
                    if (!i_state.receiving || pci[3:0] != i_state.next_seq) begin
                        reject = 1'b1;
                    end else begin
                        o_res.wr.num      = cf_num;
                        o_res.wr.pos      = i_state.rcv_cnt;
                        o_res.wr.bytes    = i_data[63:8];
                        o_res.nxt.rcv_cnt = cf_sum[LEN_W-1:0];
                        if (cf_sum >= {1'b0, i_state.exp_len}) begin
                            o_res.nxt.receiving = 1'b0;
                            o_res.status        = ST_COMPLETE;
                        end else begin
                            o_res.nxt.next_seq = i_state.next_seq + SEQ_W'(1);
                        end
                    end
                end
                PCI_FLOW: begin
                    o_res.kind = KIND_FLOW;
                end
                default: begin
                    o_res.kind = KIND_UNKNOWN;
                    reject     = 1'b1;
                end
            endcase
            // any rejection aborts the channel
            if (reject) begin
                o_res.nxt.receiving = 1'b0;
                o_res.status        = ST_REJECTED;
            end
            o_res.mlen = o_res.nxt.exp_len;
        end
    end

endmodule

[verif/isotp_reassembly_checker.sv]
`timescale 1ns / 1ps

module isotp_reassembly_checker import isotp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    isotp_in_if             i_req_mon,
    isotp_out_if            i_rsp_mon,
    isotp_cfg_if            i_cfg_mon,
    output int              o_mismatches,
    output int              o_outstanding,
    output logic [7:0][9:0] o_extent
);

    localparam int CHANNELS = ISOTP_NUM_CHANNELS;
    localparam int BUF_SIZE = ISOTP_BUFFER_BYTES;

    typedef struct {
        t_status          status;
        t_kind            kind;
        logic [LEN_W-1:0] mlen;
        logic             sfc;
        logic [63:0]      fcd;
        logic [7:0]       rbyte;
    } t_response;

    // register copies
    logic [7:0]       block_size;
    logic [7:0]       sep_time;
    logic [CFG_W-1:0] max_len;

    // per-channel reassembly state
    logic             rx_active [CHANNELS];
    logic [LEN_W-1:0] exp_len   [CHANNELS];
    logic [LEN_W-1:0] rcv_cnt   [CHANNELS];
    logic [SEQ_W-1:0] next_seq  [CHANNELS];
    logic [7:0]       msg_buf   [CHANNELS][BUF_SIZE];
    int               extent    [CHANNELS];

    t_response due_rsp [$];
    t_response want;
    int        mismatches;

    // buffer write, tracking how far each channel's buffer is filled
    task automatic store_byte(input int ch, input int pos, input logic [7:0] value);
        if (pos < BUF_SIZE) begin
            msg_buf[ch][pos] = value;
            if (pos + 1 > extent[ch])
                extent[ch] = pos + 1;
        end
    endtask

    // one request through the reassembly engine
    task automatic reassemble(input logic cmd, input logic [2:0] ch, input logic [3:0] dlc,
                              input logic [63:0] data, input logic [8:0] ridx,
                              output t_response r);
        logic [7:0]       pci;
        logic [LEN_W-1:0] len;
        logic             reject;
        int               lim;
        int               cnt;
        int               n;
        pci = data[7:0];
        reject = 1'b0;
        r.status = ST_ACCEPTED;
        r.kind = KIND_SINGLE;
        r.mlen = '0;
        r.sfc = 1'b0;
        r.fcd = '0;
        r.rbyte = '0;
        if (cmd) begin
            r.status = ST_READ;
            r.rbyte = msg_buf[ch][ridx];
        end else begin
            case (pci[7:4])
                PCI_SINGLE: begin
                    r.kind = KIND_SINGLE;
                    exp_len[ch] = {4'd0, pci};
                    if (pci == 8'd0 || pci > SF_MAX_LEN) begin
                        reject = 1'b1;
                    end else begin
                        for (int k = 0; k < pci; k++)
                            store_byte(ch, k, data[8*(k+1) +: 8]);
                        rx_active[ch] = 1'b0;
                        r.status = ST_COMPLETE;
                    end
                end
                PCI_FIRST: begin
                    r.kind = KIND_FIRST;
                    if (dlc != FF_DLC) begin
                        reject = 1'b1;
                    end else begin
                        len = {pci[3:0], data[15:8]};
                        lim = (max_len < BUF_SIZE) ? int'(max_len) : BUF_SIZE;
                        exp_len[ch] = len;
                        if (len < FF_MIN_LEN || len > lim) begin
                            reject = 1'b1;
                        end else begin
                            for (int k = 0; k < FF_STORED; k++)
                                store_byte(ch, k, data[8*(k+2) +: 8]);
                            rcv_cnt[ch] = LEN_W'(FF_STORED);
                            next_seq[ch] = FF_NEXT_SEQ;
                            rx_active[ch] = 1'b1;
                            r.sfc = 1'b1;
                            r.fcd = {40'd0, sep_time, block_size, FC_PCI_CTS};
                        end
                    end
                end
                PCI_CONSEC: begin
                    r.kind = KIND_CONSEC;
                    if (!rx_active[ch] || pci[3:0] != next_seq[ch]) begin
                        reject = 1'b1;
                    end else begin
                        cnt = int'(rcv_cnt[ch]);
                        n = int'(exp_len[ch]) - cnt;
                        if (n < 0)
                            n = 0;
                        if (n > int'(CF_MAX_BYTES))
                            n = int'(CF_MAX_BYTES);
                        for (int k = 0; k < n; k++)
                            store_byte(ch, cnt + k, data[8*(k+1) +: 8]);
                        cnt = cnt + n;
                        rcv_cnt[ch] = LEN_W'(cnt);
                        if (cnt >= int'(exp_len[ch])) begin
                            rx_active[ch] = 1'b0;
                            r.status = ST_COMPLETE;
                        end else begin
                            next_seq[ch] = next_seq[ch] + 1'b1;
                        end
                    end
                end
                PCI_FLOW: r.kind = KIND_FLOW;
                default: begin
                    r.kind = KIND_UNKNOWN;
                    reject = 1'b1;
                end
            endcase
            if (reject) begin
                rx_active[ch] = 1'b0;
                r.status = ST_REJECTED;
            end
            r.mlen = exp_len[ch];
        end
    endtask

    // responses checked first, then register writes, then new requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            block_size = CFG_BS_RST;
            sep_time = CFG_ST_RST;
            max_len = CFG_MAXLEN_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                rx_active[c] = 1'b0;
                exp_len[c] = '0;
                rcv_cnt[c] = '0;
                next_seq[c] = '0;
                extent[c] = 0;
            end
            due_rsp.delete();
            mismatches = 0;
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (due_rsp.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: response with no request waiting: status=%0d kind=%0d",
                                 $realtime, i_rsp_mon.status, i_rsp_mon.frame_kind);
                    mismatches++;
                end else begin
                    want = due_rsp.pop_front();
                    if (i_rsp_mon.status !== want.status
                            || i_rsp_mon.frame_kind !== want.kind
                            || i_rsp_mon.message_length !== want.mlen
                            || i_rsp_mon.send_flow_control !== want.sfc
                            || i_rsp_mon.flow_control_data !== want.fcd
                            || i_rsp_mon.read_byte !== want.rbyte) begin
                        if (mismatches < 10) begin
                            $display("%0t: expected status=%0d kind=%0d len=%0d fc=%0b fcd=%h rd=%h",
                                     $realtime, want.status, want.kind, want.mlen, want.sfc,
                                     want.fcd, want.rbyte);
                            $display("%0t:   actual status=%0d kind=%0d len=%0d fc=%0b fcd=%h rd=%h",
                                     $realtime, i_rsp_mon.status, i_rsp_mon.frame_kind,
                                     i_rsp_mon.message_length, i_rsp_mon.send_flow_control,
                                     i_rsp_mon.flow_control_data, i_rsp_mon.read_byte);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.reg_index)
                    CFG_BLOCK_SIZE: block_size = i_cfg_mon.wdata[7:0];
                    CFG_SEP_TIME:   sep_time = i_cfg_mon.wdata[7:0];
                    CFG_MAX_LENGTH: max_len = i_cfg_mon.wdata;
                    default: ;
                endcase
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                reassemble(i_req_mon.command, i_req_mon.channel, i_req_mon.frame_dlc,
                           i_req_mon.frame_data, i_req_mon.read_index, want);
                due_rsp.push_back(want);
            end
        end
        o_mismatches <= mismatches;
        o_outstanding <= due_rsp.size();
        for (int c = 0; c < CHANNELS; c++)
            o_extent[c] <= 10'(extent[c]);
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb import isotp_pkg::*;;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 80;

    logic i_clk;
    logic i_rst_n = 1'b0;

    isotp_in_if  req_if ();
    isotp_out_if rsp_if ();
    isotp_cfg_if cfg_if ();

    int              mismatches;
    int              outstanding;
    logic [7:0][9:0] extent;

    // stimulus-side view of each channel's message in progress
    int               cf_left [8];
    logic [3:0]       cf_seq  [8];
    logic [CFG_W-1:0] cur_max_len;

    bit no_gaps;
    int rx_hold;
    int sent;
    int reads;
    int settings;
    int idle_cycles;

    isotp_receive_reassembler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .i_cfg   (cfg_if)
    );

    isotp_reassembly_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (req_if),
        .i_rsp_mon     (rsp_if),
        .i_cfg_mon     (cfg_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_extent      (extent)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // watchdog on accepted transfers
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("isotp_receive_reassembler: mismatch");
                $finish;
            end
        end
    end

    // response side with random stalls and an occasional long hold-off
    initial begin
        int stall;
        rsp_if.ready <= 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
        end
    end

    // one request, after a random gap, held until accepted
    task automatic push_request(input logic cmd, input logic [2:0] ch, input logic [3:0] dlc,
                                input logic [63:0] data, input logic [8:0] ridx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= cmd;
        req_if.channel <= ch;
        req_if.frame_dlc <= dlc;
        req_if.frame_data <= data;
        req_if.read_index <= ridx;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        sent++;
        if (cmd)
            reads++;
    endtask

    function automatic logic [63:0] rand_fill();
        return {$urandom, $urandom};
    endfunction

    task automatic send_read(input logic [2:0] ch, input logic [8:0] idx);
        push_request(1'b1, ch, 4'($urandom_range(0, 15)), rand_fill(), idx);
    endtask

    // single frame, pci byte as given
    task automatic send_single(input logic [2:0] ch, input logic [7:0] pci,
                               input logic [63:0] fill);
        logic [63:0] data;
        data = fill;
        data[7:0] = pci;
        push_request(1'b0, ch, 4'($urandom_range(0, 15)), data, 9'($urandom_range(0, 511)));
        cf_left[ch] = 0;
    endtask

    // first frame; opens a message when well-formed
    task automatic send_first(input logic [2:0] ch, input logic [11:0] len,
                              input logic [3:0] dlc, input logic [63:0] fill);
        logic [63:0] data;
        data = fill;
        data[7:0] = {PCI_FIRST, len[11:8]};
        data[15:8] = len[7:0];
        push_request(1'b0, ch, dlc, data, 9'($urandom_range(0, 511)));
        if (dlc == FF_DLC && len >= FF_MIN_LEN && len <= cur_max_len) begin
            cf_left[ch] = int'(len) - int'(FF_STORED);
            cf_seq[ch] = FF_NEXT_SEQ;
        end else begin
            cf_left[ch] = 0;
        end
    endtask

    // consecutive frame with the given sequence number
    task automatic send_consec(input logic [2:0] ch, input logic [3:0] seq,
                               input logic [63:0] fill);
        logic [63:0] data;
        data = fill;
        data[7:0] = {PCI_CONSEC, seq};
        push_request(1'b0, ch, 4'($urandom_range(0, 15)), data, 9'($urandom_range(0, 511)));
        if (cf_left[ch] > 0 && seq == cf_seq[ch]) begin
            cf_left[ch] = cf_left[ch] - ((cf_left[ch] > 7) ? 7 : cf_left[ch]);
            cf_seq[ch] = cf_seq[ch] + 1'b1;
        end else begin
            cf_left[ch] = 0;
        end
    endtask

    // flow control or unknown pci; anything but flow control aborts
    task automatic send_other(input logic [2:0] ch, input logic [7:0] pci,
                              input logic [63:0] fill);
        logic [63:0] data;
        data = fill;
        data[7:0] = pci;
        push_request(1'b0, ch, 4'($urandom_range(0, 15)), data, 9'($urandom_range(0, 511)));
        if (pci[7:4] != PCI_FLOW)
            cf_left[ch] = 0;
    endtask

    // stop offering requests until every response is back
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_setting(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_MAX_LENGTH)
            cur_max_len = value;
    endtask

    task automatic apply_settings(input logic [7:0] bs, input logic [7:0] st,
                                  input logic [CFG_W-1:0] max_len);
        drain();
        write_setting(CFG_BLOCK_SIZE, {1'b0, bs});
        write_setting(CFG_SEP_TIME, {1'b0, st});
        write_setting(CFG_MAX_LENGTH, max_len);
        settings++;
    endtask

    // mostly well-formed interleaved messages, some reads, some noise
    task automatic run_traffic(input int count);
        logic [2:0]  ch;
        logic [7:0]  pci;
        logic [11:0] len;
        int          pick;
        int          sub;
        int          cap;
        repeat (count) begin
            ch = 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            if (pick < 10 && extent[ch] != 0) begin
                send_read(ch, 9'($urandom_range(0, int'(extent[ch]) - 1)));
            end else if (pick < 16) begin
                // random pci byte
                pci = 8'($urandom_range(0, 255));
                case (pci[7:4])
                    PCI_SINGLE: send_single(ch, pci, rand_fill());
                    PCI_FIRST:  send_first(ch, {pci[3:0], 8'($urandom_range(0, 255))},
                                           4'($urandom_range(0, 15)), rand_fill());
                    PCI_CONSEC: send_consec(ch, pci[3:0], rand_fill());
                    default:    send_other(ch, pci, rand_fill());
                endcase
            end else if (pick < 22) begin
                // broken sequences
                if (sub < 50)
                    send_consec(ch, cf_seq[ch] + 4'($urandom_range(1, 15)), rand_fill());
                else
                    send_first(ch, 12'($urandom_range(8, int'(cur_max_len))),
                               4'($urandom_range(0, 7)), rand_fill());
            end else if (cf_left[ch] > 0) begin
                send_consec(ch, cf_seq[ch], rand_fill());
            end else if (sub < 30) begin
                send_single(ch, 8'($urandom_range(1, 7)), rand_fill());
            end else if (sub < 35) begin
                send_other(ch, {PCI_FLOW, 4'($urandom_range(0, 15))}, rand_fill());
            end else begin
                cap = (cur_max_len < 40) ? int'(cur_max_len) : 40;
                if (sub < 38)
                    len = 12'(cur_max_len);
                else if (sub < 42)
                    len = 12'($urandom_range(8, int'(cur_max_len)));
                else
                    len = 12'($urandom_range(8, cap));
                send_first(ch, len, FF_DLC, rand_fill());
            end
        end
    endtask

    // main sequence
    initial begin
        req_if.valid <= 1'b0;
        req_if.command <= 1'b0;
        req_if.channel <= '0;
        req_if.frame_dlc <= '0;
        req_if.frame_data <= '0;
        req_if.read_index <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.reg_index <= CFG_BLOCK_SIZE;
        cfg_if.wdata <= '0;
        no_gaps = 1'b0;
        rx_hold = 0;
        sent = 0;
        reads = 0;
        settings = 1;
        cur_max_len = CFG_MAXLEN_RST;
        for (int c = 0; c < 8; c++) begin
            cf_left[c] = 0;
            cf_seq[c] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: length limits, bad dlc, restart, wrong sequence, flow-control and unknown frames, reads
        send_single(3'd0, 8'd1, rand_fill());
        send_single(3'd1, SF_MAX_LEN, '1);
        send_single(3'd2, 8'd0, '0);
        send_single(3'd2, 8'h0F, '1);
        send_first(3'd3, 12'd20, 4'd7, rand_fill());
        send_first(3'd3, 12'd7, FF_DLC, rand_fill());
        send_first(3'd3, 12'hFFF, FF_DLC, '1);
        send_first(3'd3, 12'd261, FF_DLC, rand_fill());
        send_first(3'd3, 12'd260, FF_DLC, rand_fill());
        send_first(3'd4, 12'd20, FF_DLC, rand_fill());
        send_consec(3'd4, 4'd1, rand_fill());
        send_consec(3'd4, 4'd2, rand_fill());
        send_consec(3'd4, 4'd3, rand_fill());
        send_first(3'd5, 12'd10, FF_DLC, rand_fill());
        send_first(3'd5, 12'd9, FF_DLC, rand_fill());
        send_consec(3'd5, 4'd1, '0);
        send_first(3'd6, 12'd30, FF_DLC, rand_fill());
        send_consec(3'd6, 4'd2, rand_fill());
        send_other(3'd7, {PCI_FLOW, 4'h0}, rand_fill());
        send_other(3'd7, 8'h40, rand_fill());
        send_other(3'd7, 8'hFF, '1);
        send_read(3'd1, 9'd6);
        send_read(3'd4, 9'd19);
        send_read(3'd0, 9'd0);

        // smallest length limit
        apply_settings(8'hFF, 8'h00, 9'd8);
        send_first(3'd0, 12'd8, FF_DLC, rand_fill());
        send_consec(3'd0, 4'd1, rand_fill());
        send_first(3'd1, 12'd9, FF_DLC, rand_fill());
        run_traffic(120);

        // largest length limit, with back-pressure and a quiet stretch
        apply_settings(8'hA5, 8'hFF, 9'd511);
        run_traffic(60);
        rx_hold = HOLD_CYCLES;
        run_traffic(30);
        drain();
        no_gaps = 1'b1;
        run_traffic(60);
        no_gaps = 1'b0;

        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       9'($urandom_range(8, 511)));
        run_traffic(150);

        apply_settings(8'h5A, 8'h01, 9'd300);
        run_traffic(180);

        drain();
        $display("run covered %0d requests (%0d buffer reads) under %0d register settings",
                 sent, reads, settings);
        if (mismatches == 0 && outstanding == 0)
            $display("isotp_receive_reassembler: match");
        else
            $display("isotp_receive_reassembler: mismatch");
        $finish;
    end

endmodule
